[sv/fcc_pkg.sv]
// Shared types, character codes and character-class functions for the
// formula charge and token counter. No dependencies.
`default_nettype none

package fcc_pkg;

    localparam logic [7:0] ChrEnd   = 8'd0;
    localparam logic [7:0] ChrElec  = 8'd101;  // 'e'
    localparam logic [7:0] ChrPlus  = 8'd43;   // '+'
    localparam logic [7:0] ChrMinus = 8'd45;   // '-'
    localparam logic [7:0] ChrZero  = 8'd48;   // '0'

    localparam logic [7:0] CountMax = 8'd255;
    localparam logic [7:0] DigitMax = 8'd255;

    // Parser phase, one-hot.
    typedef enum logic [7:0] {
        PH_BOUND = 8'b0000_0001,
        PH_WS    = 8'b0000_0010,
        PH_SYM   = 8'b0000_0100,
        PH_ELEC  = 8'b0000_1000,
        PH_COEF  = 8'b0001_0000,
        PH_SIGN  = 8'b0010_0000,
        PH_CHG   = 8'b0100_0000,
        PH_ERR   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic signed [7:0] net_charge;
        logic [7:0]        token_count;
        logic              parse_error;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return c inside {[8'd97:8'd122]};
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return c inside {[8'd65:8'd90]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'd48:8'd57]};
    endfunction

endpackage

`default_nettype wire

[sv/fcc_parser.sv]
// Parser state and per-byte update for the formula charge and token counter.
// Depends on fcc_pkg.
`default_nettype none

module fcc_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      chr,
    output logic                 emit,
    output fcc_pkg::result_t     result
);

    fcc_pkg::phase_t   phase_reg, phase_next;
    logic              neg_reg, neg_next;
    logic [7:0]        dig_reg, dig_next;
    logic signed [7:0] tot_reg, tot_next;
    logic [7:0]        tok_reg, tok_next;

    logic              do_sym;
    logic              do_coef;
    logic              do_bound;
    logic              do_add;
    logic              is_err;
    logic [7:0]        mag;
    logic signed [9:0] sum;
    logic signed [7:0] tot_sat;
    logic [11:0]       dig_x10;
    logic [3:0]        digit_val;
    logic [8:0]        count_sum;

    assign digit_val = 4'(chr - fcc_pkg::ChrZero);
    assign dig_x10   = {1'b0, dig_reg, 3'b000} + {3'b000, dig_reg, 1'b0}
                       + {8'd0, digit_val};
    assign mag       = (phase_reg == fcc_pkg::PH_SIGN) ? 8'd1 : dig_reg;
    assign sum       = 10'(tot_reg) + (neg_reg ? -$signed({2'b00, mag})
                                               : $signed({2'b00, mag}));

    always_comb
    begin
        if (sum > 10'sd127)
        begin
            tot_sat = 8'sd127;
        end
        else if (sum < -10'sd128)
        begin
            tot_sat = -8'sd128;
        end
        else
        begin
            tot_sat = sum[7:0];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        dig_next   = dig_reg;
        tot_next   = tot_reg;
        tok_next   = tok_reg;
        emit       = 1'b0;
        is_err     = 1'b0;
        do_sym     = 1'b0;
        do_coef    = 1'b0;
        do_bound   = 1'b0;
        do_add     = 1'b0;

        case (phase_reg)
            fcc_pkg::PH_WS:
            begin
                if (chr == fcc_pkg::ChrEnd)
                begin
                    emit   = 1'b1;
                    is_err = 1'b1;
                end
                else if (!fcc_pkg::is_ws(chr))
                begin
                    do_bound = 1'b1;
                end
            end
            fcc_pkg::PH_SYM:
            begin
                if (!fcc_pkg::is_lower(chr))
                begin
                    do_sym = 1'b1;
                end
            end
            fcc_pkg::PH_ELEC:
            begin
                do_sym = 1'b1;
            end
            fcc_pkg::PH_COEF:
            begin
                if (!fcc_pkg::is_digit(chr))
                begin
                    do_coef = 1'b1;
                end
            end
            fcc_pkg::PH_SIGN:
            begin
                if (fcc_pkg::is_digit(chr))
                begin
                    dig_next   = {4'd0, digit_val};
                    phase_next = fcc_pkg::PH_CHG;
                end
                else
                begin
                    do_add   = 1'b1;
                    do_bound = 1'b1;
                end
            end
            fcc_pkg::PH_CHG:
            begin
                if (fcc_pkg::is_digit(chr))
                begin
                    dig_next = (dig_x10 > 12'(fcc_pkg::DigitMax)) ? fcc_pkg::DigitMax
                                                                  : dig_x10[7:0];
                end
                else
                begin
                    do_add   = 1'b1;
                    do_bound = 1'b1;
                end
            end
            fcc_pkg::PH_ERR:
            begin
                if (chr == fcc_pkg::ChrEnd)
                begin
                    emit   = 1'b1;
                    is_err = 1'b1;
                end
            end
            default:
            begin
                do_bound = 1'b1;
            end
        endcase

        // After a symbol, digits form the coefficient.
        if (do_sym)
        begin
            if (fcc_pkg::is_digit(chr))
            begin
                phase_next = fcc_pkg::PH_COEF;
            end
            else
            begin
                do_coef = 1'b1;
            end
        end

        // After the coefficient, a sign opens the charge.
        if (do_coef)
        begin
            if (chr == fcc_pkg::ChrPlus || chr == fcc_pkg::ChrMinus)
            begin
                neg_next   = (chr == fcc_pkg::ChrMinus);
                dig_next   = 8'd0;
                phase_next = fcc_pkg::PH_SIGN;
            end
            else
            begin
                do_bound = 1'b1;
            end
        end

        if (do_add)
        begin
            tot_next = tot_sat;
        end

        // Token boundary: end of formula, whitespace or a new symbol; any other byte is an error.
        if (do_bound)
        begin
            if (chr == fcc_pkg::ChrEnd)
            begin
                emit = 1'b1;
            end
            else if (fcc_pkg::is_ws(chr))
            begin
                phase_next = fcc_pkg::PH_WS;
            end
            else if (chr == fcc_pkg::ChrElec)
            begin
                phase_next = fcc_pkg::PH_ELEC;
            end
            else if (fcc_pkg::is_upper(chr) || fcc_pkg::is_lower(chr))
            begin
                if (tok_reg != fcc_pkg::CountMax)
                begin
                    tok_next = tok_reg + 8'd1;
                end
                phase_next = fcc_pkg::PH_SYM;
            end
            else
            begin
                phase_next = fcc_pkg::PH_ERR;
            end
        end

        count_sum = {1'b0, tok_next} + {8'd0, (tot_next != 8'sd0)};
        if (is_err)
        begin
            result.net_charge  = 8'sd0;
            result.token_count = 8'd0;
            result.parse_error = 1'b1;
        end
        else
        begin
            result.net_charge  = tot_next;
            result.token_count = count_sum[8] ? fcc_pkg::CountMax : count_sum[7:0];
            result.parse_error = 1'b0;
        end

        // A finished formula returns the parser to its start.
        if (emit)
        begin
            phase_next = fcc_pkg::PH_BOUND;
            neg_next   = 1'b0;
            dig_next   = 8'd0;
            tot_next   = 8'sd0;
            tok_next   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fcc_pkg::PH_BOUND;
            neg_reg   <= 1'b0;
            dig_reg   <= 8'd0;
            tot_reg   <= 8'sd0;
            tok_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            dig_reg   <= dig_next;
            tot_reg   <= tot_next;
            tok_reg   <= tok_next;
        end
    end

    // A result leaves the parser at its start with nothing counted.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && emit |=> phase_reg == fcc_pkg::PH_BOUND && tok_reg == 8'd0
                         && tot_reg == 8'sd0)
        else $error("parser state not cleared after a result");

    // An error result carries no charge and no count.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit && result.parse_error |-> result.net_charge == 8'sd0
                                       && result.token_count == 8'd0)
        else $error("error result with nonzero fields");

    // A result comes exactly on the terminating byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        step |-> emit == (chr == fcc_pkg::ChrEnd))
        else $error("result not tied to the terminating byte");

    // The phase register stays one-hot.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parser phase not one-hot");

endmodule

`default_nettype wire

[sv/formula_charge_and_token_count_top.sv]
// Top level of the formula charge and token counter: input register, parser
// and result register. Depends on fcc_pkg and fcc_parser.
//
//  Channel  Handshake            Payload                                Width
//  -------  -------------------  -------------------------------------  -----
//  input    in_valid / in_ready  chr                                    8
//  output   out_valid/out_ready  net_charge, token_count, parse_error   8,8,1
//
// Each byte passes through the input register, and the parser updates its
// state as the byte leaves it; one byte a cycle is sustained unless a zero
// byte is held back. A terminating zero byte writes its result into the
// result register as it leaves; the result register holds it until out_ready is seen.
// Ordinary bytes never wait on the output side. A zero byte waits in the
// input register only while an earlier result is still untaken.
// Reset (rst_n low, asynchronous) empties both registers and puts the
// parser at the start of a formula.
`default_nettype none

module formula_charge_and_token_count_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        chr,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [7:0]      net_charge,
    output logic [7:0]             token_count,
    output logic                   parse_error
);

    // Input register: one byte waiting for the parser.
    logic              in_valid_reg;
    logic [7:0]        chr_reg;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    fcc_pkg::result_t  res_reg;

    logic              advance;
    logic              emit;
    fcc_pkg::result_t  res;

    // A byte moves on unless it is a terminator and the result register is
    // still occupied by a result nobody has taken.
    assign advance  = in_valid_reg
                      && (chr_reg != fcc_pkg::ChrEnd || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            chr_reg <= chr;
        end
    end

    fcc_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .chr    (chr_reg),
        .emit   (emit),
        .result (res)
    );

    always_comb
    begin
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign net_charge  = res_reg.net_charge;
    assign token_count = res_reg.token_count;
    assign parse_error = res_reg.parse_error;

    // A new result is never written over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |-> !out_valid_reg || out_ready)
        else $error("result overwritten before it was taken");

    // A byte that cannot move on stays in the input register unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(chr_reg))
        else $error("stalled byte lost from the input register");

    // Only a stalled terminator can block the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> chr_reg == fcc_pkg::ChrEnd && out_valid_reg && !out_ready)
        else $error("input blocked without a waiting terminator");

endmodule

`default_nettype wire

[dv/formula_result_checker.sv]
// Checker for the formula charge and token counter: watches both channels, predicts
// each result from the accepted bytes and compares it field by field.
// Depends on fcc_pkg for the phase encoding, the result struct and the character codes.
module formula_result_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        chr,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic signed [7:0] net_charge,
    input  logic [7:0]        token_count,
    input  logic              parse_error,
    output int                mismatches,
    output int                pending,
    output int                results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // What a byte still has to be tried against once the current phase has passed it on.
    typedef enum logic [1:0] {
        FOLLOW_NONE,
        FOLLOW_BOUNDARY,
        FOLLOW_COEF,
        FOLLOW_SYMBOL
    } follow_t;

    fcc_pkg::phase_t  phase;
    logic             minus_sign;
    int               digit_value;
    int               charge_sum;
    int               tokens_counted;
    fcc_pkg::result_t expected_q[$];

    function automatic bit blank_chr(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit lower_chr(input logic [7:0] c);
        return c >= 8'd97 && c <= 8'd122;
    endfunction

    function automatic bit upper_chr(input logic [7:0] c);
        return c >= 8'd65 && c <= 8'd90;
    endfunction

    function automatic bit digit_chr(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic void clear_parser();
        phase = fcc_pkg::PH_BOUND;
        minus_sign = 1'b0;
        digit_value = 0;
        charge_sum = 0;
        tokens_counted = 0;
    endfunction

    function automatic void add_charge(input int amount);
        charge_sum = charge_sum + amount;
        if (charge_sum > 127)
            charge_sum = 127;
        if (charge_sum < -128)
            charge_sum = -128;
    endfunction

    function automatic fcc_pkg::result_t close_formula(input bit malformed);
        fcc_pkg::result_t r;
        int               n;
        n = tokens_counted + ((charge_sum != 0) ? 1 : 0);
        if (n > fcc_pkg::CountMax)
            n = fcc_pkg::CountMax;
        r.net_charge  = malformed ? 8'sd0 : charge_sum[7:0];
        r.token_count = malformed ? 8'd0 : n[7:0];
        r.parse_error = malformed;
        clear_parser();
        return r;
    endfunction

    // Advances the parser by one byte; returns 1 when the byte closes a formula.
    function automatic bit formula_step(input logic [7:0] c, output fcc_pkg::result_t r);
        follow_t next;
        int      v;
        next = FOLLOW_NONE;
        r = '0;
        case (phase)
            fcc_pkg::PH_WS:
            begin
                if (c == fcc_pkg::ChrEnd)
                begin
                    r = close_formula(1'b1);
                    return 1'b1;
                end
                if (!blank_chr(c))
                    next = FOLLOW_BOUNDARY;
            end
            fcc_pkg::PH_SYM:
            begin
                if (!lower_chr(c))
                    next = FOLLOW_SYMBOL;
            end
            fcc_pkg::PH_ELEC:
                next = FOLLOW_SYMBOL;
            fcc_pkg::PH_COEF:
            begin
                if (!digit_chr(c))
                    next = FOLLOW_COEF;
            end
            fcc_pkg::PH_SIGN:
            begin
                if (digit_chr(c))
                begin
                    digit_value = c - fcc_pkg::ChrZero;
                    phase = fcc_pkg::PH_CHG;
                end
                else
                begin
                    add_charge(minus_sign ? -1 : 1);
                    next = FOLLOW_BOUNDARY;
                end
            end
            fcc_pkg::PH_CHG:
            begin
                if (digit_chr(c))
                begin
                    v = digit_value * 10 + (c - fcc_pkg::ChrZero);
                    digit_value = (v > fcc_pkg::DigitMax) ? fcc_pkg::DigitMax : v;
                end
                else
                begin
                    add_charge(minus_sign ? -digit_value : digit_value);
                    next = FOLLOW_BOUNDARY;
                end
            end
            fcc_pkg::PH_ERR:
            begin
                if (c == fcc_pkg::ChrEnd)
                begin
                    r = close_formula(1'b1);
                    return 1'b1;
                end
            end
            default:
                next = FOLLOW_BOUNDARY;
        endcase

        if (next == FOLLOW_SYMBOL)
        begin
            if (digit_chr(c))
            begin
                phase = fcc_pkg::PH_COEF;
                next = FOLLOW_NONE;
            end
            else
                next = FOLLOW_COEF;
        end
        if (next == FOLLOW_COEF)
        begin
            if (c == fcc_pkg::ChrPlus || c == fcc_pkg::ChrMinus)
            begin
                minus_sign = (c == fcc_pkg::ChrMinus);
                digit_value = 0;
                phase = fcc_pkg::PH_SIGN;
                next = FOLLOW_NONE;
            end
            else
                next = FOLLOW_BOUNDARY;
        end
        if (next == FOLLOW_BOUNDARY)
        begin
            if (c == fcc_pkg::ChrEnd)
            begin
                r = close_formula(1'b0);
                return 1'b1;
            end
            if (blank_chr(c))
                phase = fcc_pkg::PH_WS;
            else if (c == fcc_pkg::ChrElec)
                phase = fcc_pkg::PH_ELEC;
            else if (upper_chr(c) || lower_chr(c))
            begin
                if (tokens_counted < fcc_pkg::CountMax)
                    tokens_counted++;
                phase = fcc_pkg::PH_SYM;
            end
            else
                phase = fcc_pkg::PH_ERR;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    initial
    begin
        mismatches = 0;
        results_checked = 0;
        pending = 0;
    end

    // Results are checked before the byte of the same edge is predicted; a byte
    // accepted now can only show up as a result on a later edge.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        fcc_pkg::result_t got;
        fcc_pkg::result_t want;
        if (!rst_n)
        begin
            clear_parser();
            expected_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result arrived with nothing expected");
                else
                begin
                    want = expected_q.pop_front();
                    results_checked++;
                    if (net_charge !== want.net_charge)
                        report_mismatch($sformatf("net_charge got %0d want %0d",
                                                  net_charge, want.net_charge));
                    if (token_count !== want.token_count)
                        report_mismatch($sformatf("token_count got %0d want %0d",
                                                  token_count, want.token_count));
                    if (parse_error !== want.parse_error)
                        report_mismatch($sformatf("parse_error got %b want %b",
                                                  parse_error, want.parse_error));
                end
            end
            if (in_valid && in_ready)
            begin
                if (formula_step(chr, got))
                    expected_q.push_back(got);
            end
        end
        pending = expected_q.size();
    end

endmodule

[dv/formula_charge_and_token_count_top_test.sv]
// Testbench top for the formula charge and token counter: clock, reset, byte stimulus,
// output back-pressure, watchdog and verdict.
// Depends on fcc_pkg, formula_charge_and_token_count_top and formula_result_checker.
module formula_charge_and_token_count_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // A run with no handshake on either side for this many cycles is a hang.
    // The deliberate output hold is far shorter than this.
    localparam int IdleLimit   = 2000;
    localparam int HoldCycles  = 400;
    localparam int DrainCycles = 8;
    localparam int TargetItems = 1000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        chr;
    logic              out_valid;
    logic              out_ready;
    logic signed [7:0] net_charge;
    logic [7:0]        token_count;
    logic              parse_error;

    int mismatch_count;
    int pending_results;
    int results_checked;

    int sent_items = 0;
    int formulas   = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    // Set by the stimulus once; the receiver clears it after the long hold.
    bit hold_output = 1'b0;

    formula_charge_and_token_count_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .chr        (chr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .net_charge (net_charge),
        .token_count(token_count),
        .parse_error(parse_error)
    );

    // The checker sees the same pins as the block and owns all prediction.
    formula_result_checker results_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .chr            (chr),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .net_charge     (net_charge),
        .token_count    (token_count),
        .parse_error    (parse_error),
        .mismatches     (mismatch_count),
        .pending        (pending_results),
        .results_checked(results_checked)
    );

    // 12 ns clock, starting low.
    initial
        clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offers one byte from a falling edge and returns on a falling edge once it has
    // been taken. Valid stays high across a burst; between bursts the sender may drop
    // valid for a random gap. Ready is read at the rising edge, before the block's
    // registers update, so the handshake seen here is the one the block sees.
    task automatic put_byte(input logic [7:0] c);
        int gap;
        in_valid <= 1'b1;
        chr      <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // Sends the characters of a string and then the terminating zero byte.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
        put_byte(fcc_pkg::ChrEnd);
        formulas++;
    endtask

    function automatic logic [7:0] any_blank();
        return ($urandom_range(0, 5) == 0) ? 8'd32 : 8'($urandom_range(9, 13));
    endfunction

    function automatic logic [7:0] any_digit();
        return 8'(fcc_pkg::ChrZero + $urandom_range(0, 9));
    endfunction

    // One random formula. Most are well formed: tokens with random symbols
    // (electrons among them), coefficients and charges, sometimes with leading or
    // trailing whitespace. The rest are noise bytes over the whole nonzero range,
    // which mostly land in the error path.
    task automatic random_formula();
        int r;
        if ($urandom_range(0, 9) < 2)
        begin
            repeat ($urandom_range(1, 8))
                put_byte(8'($urandom_range(1, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 4) == 0)
                    put_byte(any_blank());
                r = $urandom_range(0, 9);
                if (r < 2)
                    put_byte(fcc_pkg::ChrElec);
                else if (r < 4)
                    put_byte(8'($urandom_range(97, 122)));
                else
                    put_byte(8'($urandom_range(65, 90)));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2))
                        put_byte(8'($urandom_range(97, 122)));
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3))
                        put_byte(any_digit());
                if ($urandom_range(0, 2) == 0)
                begin
                    put_byte($urandom_range(0, 1) ? fcc_pkg::ChrMinus : fcc_pkg::ChrPlus);
                    // Up to four digits, so the digit value often saturates.
                    repeat ($urandom_range(0, 4))
                        put_byte(any_digit());
                end
            end
            if ($urandom_range(0, 9) == 0)
                put_byte(any_blank());
        end
        put_byte(fcc_pkg::ChrEnd);
        formulas++;
    endtask

    initial
    begin : stimulus
        in_valid = 1'b0;
        chr      = fcc_pkg::ChrEnd;
        rst_n    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. An empty formula first, then a bad token start, a byte
        // with the top bit set, trailing whitespace, an ordinary charged token,
        // an electron followed by a lowercase letter with a bare minus, and a
        // charge whose digits overflow.
        put_byte(fcc_pkg::ChrEnd);
        formulas++;
        send_text("#");
        put_byte(8'hFF);
        put_byte(fcc_pkg::ChrEnd);
        formulas++;
        send_text("H ");
        send_text("Fe2+3");
        send_text("ea-");
        send_text("H+999");

        // The receiver now holds off for a long stretch while bytes keep coming,
        // so a terminator has to wait behind an untaken result.
        hold_output = 1'b1;

        while (sent_items < TargetItems / 2)
            random_formula();

        // Enough single-letter tokens to drive the count into saturation.
        repeat (260)
            put_byte("H");
        put_byte(fcc_pkg::ChrEnd);
        formulas++;

        while (sent_items < TargetItems)
            random_formula();

        // If the last byte ended a burst, valid is already low.
        if (in_valid)
            in_valid <= 1'b0;

        while (pending_results != 0)
            @(negedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Sent %0d bytes in %0d formulas and checked %0d results,", sent_items,
                 formulas, results_checked);
        $display("including a long output hold and a token count driven into saturation.");
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Output side: stretches of random length, each with its own stall pattern,
    // from always ready to mostly stalled. The one long hold is counted here.
    initial
    begin : receiver
        int mode;
        int tick;
        out_ready = 1'b0;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(10, 60))
            begin
                @(negedge clk);
                tick++;
                if (hold_output)
                begin
                    out_ready <= 1'b0;
                    repeat (HoldCycles) @(negedge clk);
                    hold_output = 1'b0;
                end
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // Watchdog: any handshake on either side restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit)
        begin
            $display("Timed out after %0d cycles without a handshake.", IdleLimit);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
